// ===== rtl/rrmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrmt_pkg;

    // Command codes carried in the input tuser bit.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes on the configuration port.
    localparam int REG_LEAF_COUNT = 0;

    // Field widths of the stream words.
    localparam int LEAF_COUNT_BITS = 11;
    localparam int INDEX_BITS      = 10;
    localparam int AMOUNT_BITS     = 32;
    localparam int RESULT_BITS     = 32;
    localparam int IN_TDATA_BITS   = 56;

    // Bit positions inside the input tdata.
    localparam int LEFT_LSB   = 0;
    localparam int RIGHT_LSB  = LEFT_LSB + INDEX_BITS;
    localparam int AMOUNT_LSB = RIGHT_LSB + INDEX_BITS;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_VISIT,
        S_COVER,
        S_PD0,
        S_PD1,
        S_PD2,
        S_FX0,
        S_FX1,
        S_OUT
    } t_state;

    // Progress of one node on the traversal stack.
    typedef enum logic [1:0] {
        PH_ENTER,
        PH_LEFT_DONE,
        PH_RIGHT_DONE
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/rrmt_node_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single write port, single read port node store with registered read data.
module rrmt_node_mem #(
    parameter int NODES = 4096,
    parameter int AW    = 12,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [NODES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/range_add_range_max_tree_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel       Direction  Word
// s_axis        in         tdata: left, right, amount; tuser: command
// m_axis        out        tdata: range maximum
// APB           in/out     leaf_count at byte address 0
//
// A word is taken, and then the tree is walked node by node: a node outside the range is
// left at once, a covered node takes the amount on an add or gives its maximum on a query,
// and a split node pushes its pending amount down to both children; on an add its maximum
// is later rebuilt from them. The node memory takes one read and one write a cycle.
// After reset the node memory is cleared one entry a cycle, all 4*LEAVES entries,
// while s_axis_tready stays low; configuration writes are taken meanwhile.
// A finished result waits in the output register; the unit takes the next word
// and stalls only when a second result is ready before the first was taken.

module range_add_range_max_tree_unit
    import rrmt_pkg::*;
#(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Input words.
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_TDATA_BITS-1:0] s_axis_tdata,  // left[9:0], right[19:10],
                                                         // amount[51:20], zero pad
    input  wire logic [0:0]               s_axis_tuser,  // command[0]
    // Result words.
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [RESULT_BITS-1:0]        m_axis_tdata,  // range_maximum[31:0]
    // Configuration.
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [1:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int VB    = VALUE_BITS;
    localparam int NODES = 4 * LEAVES;
    localparam int NB    = $clog2(NODES);
    localparam int LB    = $clog2(LEAVES);
    localparam int CW    = (LB > INDEX_BITS) ? LB : INDEX_BITS;
    localparam int DEPTH = LB + 1;
    localparam int TW    = $clog2(DEPTH);
    localparam logic [VB-1:0] VSIGN = {1'b1, {(VB-1){1'b0}}};

    function automatic logic [VB-1:0] vmax(input logic [VB-1:0] a, input logic [VB-1:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

    // Configuration register.
    logic [LEAF_COUNT_BITS-1:0] r_leaf_count;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'(4 * REG_LEAF_COUNT));
    assign prdata = 32'(r_leaf_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LEAF_COUNT_BITS'(1024);
        end else if (cfg_wr) begin
            r_leaf_count <= pwdata[LEAF_COUNT_BITS-1:0];
        end
    end

    // Highest leaf index in use, with the count clamped to 1 .. LEAVES.
    logic [LB-1:0] root_hi;
    always_comb begin
        if (r_leaf_count == '0) begin
            root_hi = '0;
        end else if (32'(r_leaf_count) > LEAVES) begin
            root_hi = LB'(LEAVES - 1);
        end else begin
            root_hi = LB'(r_leaf_count - 1'b1);
        end
    end

    // Control and operand registers.
    t_state                r_state, n_state;
    logic [NB-1:0]         r_clr;
    logic                  r_cmd;
    logic [INDEX_BITS-1:0] r_ql, r_qr;
    logic [VB-1:0]         r_amt, r_acc, n_acc, r_p, n_p, r_tmp, n_tmp;
    logic                  r_ovalid;
    logic [RESULT_BITS-1:0] r_odata;

    // Traversal stack: one frame per tree level on the current path.
    logic [NB-1:0] r_stk_node [DEPTH];
    logic [LB-1:0] r_stk_lo   [DEPTH];
    logic [LB-1:0] r_stk_hi   [DEPTH];
    t_phase        r_stk_ph   [DEPTH];
    logic [TW-1:0] r_top;

    // Node memory: {pending_add, subtree_max} per node.
    logic              mem_we;
    logic [NB-1:0]     mem_waddr, mem_raddr;
    logic [2*VB-1:0]   mem_wdata, mem_rdata;
    logic [VB-1:0]     rd_max, rd_pend;

    rrmt_node_mem #(
        .NODES (NODES),
        .AW    (NB),
        .DW    (2 * VB)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_max  = mem_rdata[VB-1:0];
    assign rd_pend = mem_rdata[2*VB-1:VB];

    // Top frame and its children.
    logic [NB-1:0] t_node, left_node, right_node;
    logic [LB-1:0] t_lo, t_hi, mid, mid_up;
    logic [LB:0]   span_sum;
    t_phase        t_ph;
    logic          outside, covered;

    assign t_node     = r_stk_node[r_top];
    assign t_lo       = r_stk_lo[r_top];
    assign t_hi       = r_stk_hi[r_top];
    assign t_ph       = r_stk_ph[r_top];
    assign left_node  = {t_node[NB-2:0], 1'b0};
    assign right_node = {t_node[NB-2:0], 1'b1};
    assign span_sum   = {1'b0, t_lo} + {1'b0, t_hi};
    assign mid        = span_sum[LB:1];
    assign mid_up     = LB'(mid + 1'b1);
    assign outside    = (CW'(r_ql) > CW'(t_hi)) || (CW'(r_qr) < CW'(t_lo));
    assign covered    = (CW'(r_ql) <= CW'(t_lo)) && (CW'(t_hi) <= CW'(r_qr));

    // Input word fields.
    logic                  in_acc;
    logic [INDEX_BITS-1:0] in_ql, in_qr;
    logic signed [AMOUNT_BITS-1:0] in_amt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_ql  = s_axis_tdata[LEFT_LSB +: INDEX_BITS];
    assign in_qr  = s_axis_tdata[RIGHT_LSB +: INDEX_BITS];
    assign in_amt = s_axis_tdata[AMOUNT_LSB +: AMOUNT_BITS];

    // Stack actions decided by the sequencer.
    logic          start, push, pop, ph_we, out_load;
    t_phase        ph_val;
    logic [NB-1:0] push_node;
    logic [LB-1:0] push_lo, push_hi;

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_p       = r_p;
        n_tmp     = r_tmp;
        mem_we    = 1'b0;
        mem_waddr = t_node;
        mem_wdata = '0;
        mem_raddr = t_node;
        start     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        ph_we     = 1'b0;
        ph_val    = PH_ENTER;
        push_node = left_node;
        push_lo   = t_lo;
        push_hi   = mid;
        out_load  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == NB'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_acc = VSIGN;
                    if (in_ql <= in_qr) begin
                        start   = 1'b1;
                        n_state = S_VISIT;
                    end else if (s_axis_tuser[0] == CMD_QUERY) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_VISIT: begin
                unique case (t_ph)
                    PH_ENTER: begin
                        if (outside) begin
                            pop = 1'b1;
                        end else if (covered) begin
                            n_state = S_COVER;
                        end else begin
                            n_state = S_PD0;
                        end
                    end
                    PH_LEFT_DONE: begin
                        ph_we     = 1'b1;
                        ph_val    = PH_RIGHT_DONE;
                        push      = 1'b1;
                        push_node = right_node;
                        push_lo   = mid_up;
                        push_hi   = t_hi;
                    end
                    PH_RIGHT_DONE: begin
                        if (r_cmd == CMD_ADD) begin
                            mem_raddr = left_node;
                            n_state   = S_FX0;
                        end else begin
                            pop = 1'b1;
                        end
                    end
                    default: begin
                        pop = 1'b1;
                    end
                endcase
            end
            S_COVER: begin
                if (r_cmd == CMD_ADD) begin
                    mem_we    = 1'b1;
                    mem_wdata = {rd_pend + r_amt, rd_max + r_amt};
                end else begin
                    n_acc = vmax(r_acc, rd_max);
                end
                pop = 1'b1;
            end
            S_PD0: begin
                // Take the node's pending amount and clear it.
                n_p       = rd_pend;
                mem_we    = 1'b1;
                mem_wdata = {{VB{1'b0}}, rd_max};
                mem_raddr = left_node;
                n_state   = S_PD1;
            end
            S_PD1: begin
                mem_we    = 1'b1;
                mem_waddr = left_node;
                mem_wdata = {rd_pend + r_p, rd_max + r_p};
                mem_raddr = right_node;
                n_state   = S_PD2;
            end
            S_PD2: begin
                mem_we    = 1'b1;
                mem_waddr = right_node;
                mem_wdata = {rd_pend + r_p, rd_max + r_p};
                ph_we     = 1'b1;
                ph_val    = PH_LEFT_DONE;
                push      = 1'b1;
                n_state   = S_VISIT;
            end
            S_FX0: begin
                n_tmp     = rd_max;
                mem_raddr = right_node;
                n_state   = S_FX1;
            end
            S_FX1: begin
                // Pending was cleared on the way down, so only the maximum changes.
                mem_we    = 1'b1;
                mem_wdata = {{VB{1'b0}}, vmax(r_tmp, rd_max)};
                pop       = 1'b1;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (pop) begin
            if (r_top == '0) begin
                n_state = (r_cmd == CMD_QUERY) ? S_OUT : S_IDLE;
            end else begin
                n_state = S_VISIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= NB'(r_clr + 1'b1);
            end
            if (start) begin
                r_top <= '0;
            end else if (push) begin
                r_top <= TW'(r_top + 1'b1);
            end else if (pop && (r_top != '0)) begin
                r_top <= TW'(r_top - 1'b1);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_p   <= n_p;
        r_tmp <= n_tmp;
        if (in_acc) begin
            r_cmd <= s_axis_tuser[0];
            r_ql  <= in_ql;
            r_qr  <= in_qr;
            r_amt <= VB'(in_amt);
        end
        if (out_load) begin
            r_odata <= RESULT_BITS'($signed(r_acc));
        end
        if (start) begin
            r_stk_node[0] <= NB'(1);
            r_stk_lo[0]   <= '0;
            r_stk_hi[0]   <= root_hi;
            r_stk_ph[0]   <= PH_ENTER;
        end
        if (ph_we) begin
            r_stk_ph[r_top] <= ph_val;
        end
        if (push) begin
            r_stk_node[TW'(r_top + 1'b1)] <= push_node;
            r_stk_lo[TW'(r_top + 1'b1)]   <= push_lo;
            r_stk_hi[TW'(r_top + 1'b1)]   <= push_hi;
            r_stk_ph[TW'(r_top + 1'b1)]   <= PH_ENTER;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

`default_nettype wire

// ===== rtl/rrmt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrmt_checker
    import rrmt_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     s_axis_tvalid,
    input wire logic                     s_axis_tready,
    input wire logic [IN_TDATA_BITS-1:0] s_axis_tdata,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [RESULT_BITS-1:0]   m_axis_tdata
);

    // A result word that is not taken holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // The memory clearing pass keeps the input closed right after reset.
    a_clear_closed: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input open during clearing pass");

    // A word with a nonempty range keeps the unit busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tdata[LEFT_LSB +: INDEX_BITS] <= s_axis_tdata[RIGHT_LSB +: INDEX_BITS])
        |=> !s_axis_tready)
        else $error("input open right after a word was taken");

endmodule

bind range_add_range_max_tree_unit rrmt_checker u_rrmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
